FILE: hdl/dbf_field_value_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// dbf field value decoder assertion macros
// clocked assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef DBF_FIELD_VALUE_DECODER_CORE_ASSERT_SVH
`define DBF_FIELD_VALUE_DECODER_CORE_ASSERT_SVH

`ifndef SYNTH
`define DBF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DBF_ASSERT(label, prop, msg)
`define DBF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: hdl/dbf_pkg.sv
// ----------------------------------------------------------------------------
// dbf field value decoder package
// shared types, codes and byte scan helpers
// ----------------------------------------------------------------------------
package dbf_pkg;

	localparam int MAX_FIELD_BYTES_DEF = 255;
	localparam int JOB_DEPTH_DEF       = 2;

	localparam logic [1:0] MODE_INT   = 2'd0;
	localparam logic [1:0] MODE_LOGIC = 2'd1;
	localparam logic [1:0] MODE_DATE  = 2'd2;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_TRIM   = 2'd1;
	localparam logic [1:0] REG_NATIVE = 2'd2;

	localparam logic [2:0] PH_LEAD   = 3'd0;
	localparam logic [2:0] PH_SIGN   = 3'd1;
	localparam logic [2:0] PH_DIGITS = 3'd2;
	localparam logic [2:0] PH_TRAIL  = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;
	localparam logic [2:0] PH_BAD    = 3'd5;

	localparam logic [1:0] LG_MISSING = 2'd0;
	localparam logic [1:0] LG_FALSE   = 2'd2;
	localparam logic [1:0] LG_TRUE    = 2'd3;

	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

	typedef struct packed {
		logic [7:0] field_byte;
		logic       first_byte;
		logic       last_byte;
	} byte_word_t;

	typedef struct packed {
		logic signed [31:0] decoded_value;
		logic               is_missing;
	} value_word_t;

	typedef struct packed {
		logic [1:0] target_mode;
		logic       trim_enable;
		logic       native_date_field;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic        neg;
		logic [31:0] mag;
		logic        ovf;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic        bad;
		logic [1:0]  lcode;
	} scan_t;

	localparam scan_t SCAN_CLEAR = '{
		phase: PH_LEAD, neg: 1'b0, mag: 32'd0, ovf: 1'b0, year: 14'd0,
		month: 7'd0, day: 7'd0, bad: 1'b0, lcode: LG_MISSING
	};

	typedef struct packed {
		logic [1:0] mode;
		logic       native;
		scan_t      scan;
		logic       len_ge8;
	} job_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_dig(input logic [7:0] b);
		return (b >= 8'd48) && (b <= 8'd57);
	endfunction

	function automatic scan_t add_digit(input scan_t s, input logic [3:0] d);
		logic [35:0] v;
		scan_t r;
		r = s;
		v = ({4'b0, s.mag} << 3) + ({4'b0, s.mag} << 1) + {32'b0, d};
		if (v > {4'b0, MAG_LIMIT}) begin
			r.ovf = 1'b1;
			r.mag = MAG_LIMIT;
		end else begin
			r.mag = v[31:0];
		end
		return r;
	endfunction

	function automatic scan_t place_digit(input scan_t s, input logic [31:0] idx,
		input logic [3:0] d);
		scan_t r;
		r = s;
		if (idx < 32'd4)
			r.year = (s.year << 3) + (s.year << 1) + {10'b0, d};
		else if (idx < 32'd6)
			r.month = (s.month << 3) + (s.month << 1) + {3'b0, d};
		else if (idx < 32'd8)
			r.day = (s.day << 3) + (s.day << 1) + {3'b0, d};
		return r;
	endfunction

endpackage

FILE: hdl/dbf_field_value_decoder_core.sv
// ----------------------------------------------------------------------------
// dbf field value decoder core
// decodes one dbf record field, one byte per word, into one value word
// ----------------------------------------------------------------------------
// usage:
//  byte channel (byte_valid/byte_ready/byte_word) takes one field byte per
//  cycle with first/last marks; value channel (value_valid/value_ready/
//  value_word) gives one decoded value per field, after its last byte
//  config: cfg_write with cfg_index 0 mode, 1 trim, 2 native date, any time
//  the core is idle
//  path: a field's job passes the job queue, then sequencer steps S1 to S4
//  throughput: one byte per cycle while the job queue has room; the finish
//  sequencer steps through idle and S1 to S4 for every field, so short fields
//  are paced by it once the job queue (JOB_DEPTH entries) fills
//  reset: config returns to integer mode, trim on, native date on; any
//  partial field and queued jobs are dropped
//  stall: a held value word keeps the sequencer waiting; bytes are still
//  taken until the job queue is full, then byte_ready drops
// ----------------------------------------------------------------------------
module dbf_field_value_decoder_core #(
	parameter int MAX_FIELD_BYTES = dbf_pkg::MAX_FIELD_BYTES_DEF,
	parameter int JOB_DEPTH       = dbf_pkg::JOB_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  dbf_pkg::byte_word_t  byte_word,
	output logic                 value_valid,
	input  logic                 value_ready,
	output dbf_pkg::value_word_t value_word,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [1:0]           cfg_data
);
	import dbf_pkg::*;

	cfg_t cfg_q;
	job_t push_job;
	job_t pop_job;
	logic job_push;
	logic job_pop;
	logic job_full;
	logic job_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_mode       <= MODE_INT;
			cfg_q.trim_enable       <= 1'b1;
			cfg_q.native_date_field <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MODE:   cfg_q.target_mode       <= cfg_data;
				REG_TRIM:   cfg_q.trim_enable       <= cfg_data[0];
				REG_NATIVE: cfg_q.native_date_field <= cfg_data[0];
				default:    cfg_q                   <= cfg_q;
			endcase
		end
	end

	dbf_front #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_word (byte_word),
		.job_push  (job_push),
		.job       (push_job),
		.job_full  (job_full)
	);

	dbf_fifo #(
		.DEPTH(JOB_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.push_job(push_job),
		.full    (job_full),
		.pop     (job_pop),
		.pop_job (pop_job),
		.empty   (job_empty)
	);

	dbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_empty  (job_empty),
		.job_pop    (job_pop),
		.job        (pop_job),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.value_word (value_word)
	);

endmodule

FILE: hdl/dbf_front.sv
// ----------------------------------------------------------------------------
// dbf front end
// per byte scan of one field, queues a finish job at the last byte
// ----------------------------------------------------------------------------
module dbf_front #(
	parameter int MAX_FIELD_BYTES = dbf_pkg::MAX_FIELD_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dbf_pkg::cfg_t       cfg,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  dbf_pkg::byte_word_t byte_word,
	output logic                job_push,
	output dbf_pkg::job_t       job,
	input  logic                job_full
);
	import dbf_pkg::*;

	localparam int LEN_W = $clog2(MAX_FIELD_BYTES + 1);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_FIELD_BYTES);
	localparam logic [LEN_W-1:0] LEN_DATE = LEN_W'(8);

	scan_t            scan_q;
	logic [LEN_W-1:0] len_q;
	scan_t            cur;
	scan_t            nxt;
	logic [LEN_W-1:0] pos;
	logic [LEN_W-1:0] nxt_len;
	logic [7:0]       b;
	logic [3:0]       d;
	logic             accept;

	assign byte_ready = !job_full;
	assign accept     = byte_valid && byte_ready;
	assign b          = byte_word.field_byte;
	assign d          = b[3:0];

	always_comb begin
		cur = byte_word.first_byte ? SCAN_CLEAR : scan_q;
		pos = byte_word.first_byte ? '0 : len_q;
		nxt = cur;

		if (pos == '0) begin
			if (b == "Y" || b == "y" || b == "T" || b == "t")
				nxt.lcode = LG_TRUE;
			else if (b == "N" || b == "n" || b == "F" || b == "f")
				nxt.lcode = LG_FALSE;
			else
				nxt.lcode = LG_MISSING;
		end

		if (cfg.target_mode == MODE_DATE && cfg.native_date_field) begin
			if (pos < LEN_DATE) begin
				if (is_dig(b))
					nxt = place_digit(nxt, 32'(pos), d);
				else
					nxt.bad = 1'b1;
			end
		end else if (pos < LEN_MAX) begin
			if (cfg.target_mode == MODE_INT) begin
				case (cur.phase)
					PH_LEAD: begin
						if (is_ws(b)) begin
							nxt.phase = PH_LEAD;
						end else if (b == "+" || b == "-") begin
							nxt.neg   = (b == "-");
							nxt.phase = PH_SIGN;
						end else if (is_dig(b)) begin
							nxt       = add_digit(nxt, d);
							nxt.phase = PH_DIGITS;
						end else begin
							nxt.phase = PH_BAD;
						end
					end
					PH_SIGN: begin
						if (is_dig(b)) begin
							nxt       = add_digit(nxt, d);
							nxt.phase = PH_DIGITS;
						end else begin
							nxt.phase = PH_BAD;
						end
					end
					PH_DIGITS: begin
						if (is_dig(b))
							nxt = add_digit(nxt, d);
						else if (b == 8'd0)
							nxt.phase = PH_DONE;
						else if (is_ws(b) && cfg.trim_enable)
							nxt.phase = PH_TRAIL;
						else
							nxt.phase = PH_BAD;
					end
					PH_TRAIL: begin
						if (!is_ws(b))
							nxt.phase = PH_BAD;
					end
					default: begin
						nxt.phase = cur.phase;
					end
				endcase
			end else if (cfg.target_mode == MODE_DATE) begin
				case (cur.phase)
					PH_LEAD: begin
						if (cfg.trim_enable && is_ws(b)) begin
							nxt.phase = PH_LEAD;
						end else if (is_dig(b)) begin
							nxt       = place_digit(nxt, 32'd0, d);
							nxt.mag   = 32'd1;
							nxt.phase = PH_DIGITS;
						end else begin
							nxt.phase = PH_BAD;
						end
					end
					PH_DIGITS: begin
						if (cur.mag < 32'd8) begin
							if (is_dig(b)) begin
								nxt     = place_digit(nxt, cur.mag, d);
								nxt.mag = cur.mag + 32'd1;
							end else begin
								nxt.phase = PH_BAD;
							end
						end else if (b == 8'd0) begin
							nxt.phase = PH_DONE;
						end else if (is_ws(b) && cfg.trim_enable) begin
							nxt.phase = PH_TRAIL;
						end else begin
							nxt.phase = PH_BAD;
						end
					end
					PH_TRAIL: begin
						if (!is_ws(b))
							nxt.phase = PH_BAD;
					end
					default: begin
						nxt.phase = cur.phase;
					end
				endcase
			end
		end

		nxt_len = (pos < LEN_MAX) ? pos + LEN_W'(1) : pos;
	end

	assign job_push = accept && byte_word.last_byte;

	always_comb begin
		job.mode    = cfg.target_mode;
		job.native  = cfg.native_date_field;
		job.scan    = nxt;
		job.len_ge8 = (nxt_len >= LEN_DATE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= SCAN_CLEAR;
			len_q  <= '0;
		end else if (accept) begin
			if (byte_word.last_byte) begin
				scan_q <= SCAN_CLEAR;
				len_q  <= '0;
			end else begin
				scan_q <= nxt;
				len_q  <= nxt_len;
			end
		end
	end

endmodule

FILE: hdl/dbf_fifo.sv
// ----------------------------------------------------------------------------
// dbf job queue
// small flop queue of finish jobs between front and back end
// ----------------------------------------------------------------------------
`include "dbf_field_value_decoder_core_assert.svh"

module dbf_fifo #(
	parameter int DEPTH = dbf_pkg::JOB_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dbf_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output dbf_pkg::job_t pop_job,
	output logic          empty
);
	import dbf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	`DBF_ASSERT(a_fifo_no_overflow, push |-> !full, "job pushed into full queue")
	`DBF_ASSERT(a_fifo_no_underflow, pop |-> !empty, "job popped from empty queue")
	`DBF_ASSERT(a_fifo_count_bound, count_q <= CNT_FULL, "queue count beyond depth")

endmodule

FILE: hdl/dbf_back.sv
// ----------------------------------------------------------------------------
// dbf back end
// finish sequencer: integer and logical checks, days-from-civil, result register
// ----------------------------------------------------------------------------
`include "dbf_field_value_decoder_core_assert.svh"

module dbf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_empty,
	output logic                 job_pop,
	input  dbf_pkg::job_t        job,
	output logic                 value_valid,
	input  logic                 value_ready,
	output dbf_pkg::value_word_t value_word
);
	import dbf_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_S1   = 3'd1;
	localparam logic [2:0] B_S2   = 3'd2;
	localparam logic [2:0] B_S3   = 3'd3;
	localparam logic [2:0] B_S4   = 3'd4;

	logic [2:0]         state_q;
	job_t               job_q;
	logic signed [15:0] y_q;
	logic [29:0]        prod_q;
	logic [15:0]        t_q;
	logic               ok_q;
	logic               date_q;
	logic [31:0]        val_q;
	logic signed [5:0]  era_q;
	logic [8:0]         yoe_q;
	logic [9:0]         doy_q;
	logic [17:0]        doe_q;
	logic               value_valid_q;
	value_word_t        value_word_q;

	// stage 1 terms
	logic [6:0]         mon;
	logic [6:0]         dy;
	logic signed [15:0] y_d;
	logic [13:0]        y_pos;
	logic [29:0]        prod_d;
	logic [7:0]         mp;
	logic [15:0]        t_d;
	logic               int_ok;
	logic [31:0]        int_val;
	logic               shape_ok;
	logic               range_ok;
	logic               ok_d;
	logic [31:0]        val_d;
	// stage 2 terms
	logic signed [5:0]  era_d;
	logic signed [15:0] era_x;
	logic signed [15:0] yoe_w;
	logic [30:0]        tq;
	logic [14:0]        doy_w;
	// stage 3 terms
	logic [17:0]        y365;
	logic [15:0]        y41;
	logic [17:0]        doe_d;
	// stage 4 terms
	logic signed [31:0] days;
	logic               out_free;

	assign job_pop     = (state_q == B_IDLE) && !job_empty;
	assign out_free    = !value_valid_q || value_ready;
	assign value_valid = value_valid_q;
	assign value_word  = value_word_q;

	always_comb begin
		mon    = job_q.scan.month;
		dy     = job_q.scan.day;
		y_d    = $signed({2'b0, job_q.scan.year}) - ((mon <= 7'd2) ? 16'sd1 : 16'sd0);
		y_pos  = y_d[15] ? 14'd0 : y_d[13:0];
		prod_d = {16'b0, y_pos} * 30'd41944;
		mp     = (mon > 7'd2) ? {1'b0, mon} - 8'd3 : {1'b0, mon} + 8'd9;
		t_d    = {8'b0, mp} * 16'd153 + 16'd2;

		int_ok = (job_q.scan.phase inside {PH_DIGITS, PH_DONE, PH_TRAIL}) &&
			!job_q.scan.ovf && (job_q.scan.neg || job_q.scan.mag < MAG_LIMIT);
		int_val = job_q.scan.neg ? 32'd0 - job_q.scan.mag : job_q.scan.mag;

		if (job_q.native)
			shape_ok = job_q.len_ge8 && !job_q.scan.bad;
		else
			shape_ok = (job_q.scan.phase == PH_DONE) || (job_q.scan.phase == PH_TRAIL) ||
				(job_q.scan.phase == PH_DIGITS && job_q.scan.mag == 32'd8);
		range_ok = (mon >= 7'd1) && (mon <= 7'd12) && (dy >= 7'd1) && (dy <= 7'd31);

		case (job_q.mode)
			MODE_INT: begin
				ok_d  = int_ok;
				val_d = int_val;
			end
			MODE_LOGIC: begin
				ok_d  = (job_q.scan.lcode != LG_MISSING);
				val_d = (job_q.scan.lcode == LG_TRUE) ? 32'd1 : 32'd0;
			end
			MODE_DATE: begin
				ok_d  = shape_ok && range_ok;
				val_d = 32'd0;
			end
			default: begin
				ok_d  = 1'b0;
				val_d = 32'd0;
			end
		endcase
	end

	always_comb begin
		era_d = y_q[15] ? -6'sd1 : $signed(prod_q[29:24]);
		era_x = 16'(era_d);
		yoe_w = y_q - era_x * 16'sd400;
		tq    = {15'b0, t_q} * 31'd13108;
		doy_w = tq[30:16] + {8'b0, job_q.scan.day} - 15'd1;

		y365  = {9'b0, yoe_q} * 18'd365;
		y41   = {7'b0, yoe_q} * 16'd41;
		doe_d = y365 + 18'(yoe_q >> 2) - 18'(y41[15:12]) + 18'(doy_q);

		days  = 32'(era_q) * 32'sd146097 + $signed({14'b0, doe_q}) - 32'sd719468;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!job_empty)
					job_q <= job;
			end
			B_S1: begin
				y_q    <= y_d;
				prod_q <= prod_d;
				t_q    <= t_d;
				ok_q   <= ok_d;
				val_q  <= val_d;
				date_q <= (job_q.mode == MODE_DATE);
			end
			B_S2: begin
				era_q <= era_d;
				yoe_q <= yoe_w[8:0];
				doy_q <= doy_w[9:0];
			end
			B_S3: begin
				doe_q <= doe_d;
			end
			B_S4: begin
				if (out_free) begin
					value_word_q.decoded_value <= !ok_q ? 32'sd0 :
						(date_q ? days : $signed(val_q));
					value_word_q.is_missing <= !ok_q;
				end
			end
			default: begin
				doe_q <= doe_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			value_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!job_empty)
						state_q <= B_S1;
				end
				B_S1: state_q <= B_S2;
				B_S2: state_q <= B_S3;
				B_S3: state_q <= B_S4;
				B_S4: begin
					if (out_free)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			if (state_q == B_S4 && out_free)
				value_valid_q <= 1'b1;
			else if (value_ready)
				value_valid_q <= 1'b0;
		end
	end

	`DBF_ASSERT(a_missing_is_zero, value_valid && value_word.is_missing |-> value_word.decoded_value == 32'sd0, "missing word carries nonzero value")
	`DBF_ASSERT(a_result_from_s4, $rose(value_valid) |-> $past(state_q) == B_S4, "result word not produced by final step")
	`DBF_ASSERT_NEXT(a_s1_after_pop, job_pop, state_q == B_S1, "popped job did not start sequencer")

endmodule
